/* rtl/msc_pkg.sv */
// Package with the shared types and constants of the MOSI snoop coherence controller.
`default_nettype none

package msc_pkg;

   // Table geometry and field widths.
   localparam int LINES     = 256;
   localparam int LINE_BITS = $clog2(LINES);
   localparam int ADDR_BITS = 32;
   localparam int ID_BITS   = 4;
   localparam int LINE_W    = 8;

   // Coherence state codes as stored in the line table.
   typedef enum logic [2:0] {
      ST_I  = 3'd0,
      ST_S  = 3'd1,
      ST_O  = 3'd2,
      ST_M  = 3'd3,
      ST_IS = 3'd4,
      ST_IM = 3'd5,
      ST_SM = 3'd6
   } line_state_type;

   // Message codes carried by processor requests and snooped bus messages.
   typedef enum logic [2:0] {
      MSG_LOAD  = 3'd0,
      MSG_STORE = 3'd1,
      MSG_GETS  = 3'd2,
      MSG_GETM  = 3'd3,
      MSG_DATA  = 3'd4
   } msg_type;

   // Sequencer states of the read-modify-write loop.
   typedef enum logic {
      CTL_IDLE,
      CTL_LOOKUP
   } ctl_state_type;

   // One line table entry.
   typedef struct packed {
      logic       owner;
      logic [2:0] state;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // Request payload, last field in the lowest bits.
   typedef struct packed {
      logic                 shared_in;
      logic [ID_BITS-1:0]   src_id;
      logic [ADDR_BITS-1:0] addr;
      logic [LINE_W-1:0]    line;
      logic [2:0]           msg;
   } req_type;

   // Result payload, last field in the lowest bits.
   typedef struct packed {
      logic                 error;
      logic                 miss;
      logic [ADDR_BITS-1:0] addr_out;
      logic                 assert_shared;
      logic [ID_BITS-1:0]   dest_id;
      logic                 data_on_bus;
      logic                 data_to_cpu;
      logic                 issue_getm;
      logic                 issue_gets;
   } rsp_type;

   localparam int REQ_W      = $bits(req_type);
   localparam int RSP_W      = $bits(rsp_type);
   localparam int RSP_BYTE_W = ((RSP_W + 7) / 8) * 8;

endpackage

`default_nettype wire

/* rtl/msc_ram.sv */
// Generic simple dual-port RAM with one write port and one registered read port.
`default_nettype none

module msc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // Registered read; the data holds while no read is enabled.
   always_ff @(posedge clock) begin
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule

`default_nettype wire

/* rtl/msc_xform.sv */
// MOSI transition function: next line entry and result for one request.
`default_nettype none

module msc_xform (
   input  wire logic               snoop,
   input  wire msc_pkg::req_type   req,
   input  wire msc_pkg::entry_type cur,
   output msc_pkg::entry_type      nxt,
   output logic                    write_en,
   output msc_pkg::rsp_type        rsp
);

   msc_pkg::line_state_type st;
   msc_pkg::line_state_type nst;
   msc_pkg::msg_type        msg;
   logic nown;
   logic gets, getm, tocpu, onbus, shr, miss, err, ignore;
   logic emit;

   assign st  = msc_pkg::line_state_type'(cur.state);
   assign msg = msc_pkg::msg_type'(req.msg);

   // Protocol transitions.
   always_comb begin
      nst    = st;
      nown   = cur.owner;
      gets   = 1'b0;
      getm   = 1'b0;
      tocpu  = 1'b0;
      onbus  = 1'b0;
      shr    = 1'b0;
      miss   = 1'b0;
      err    = 1'b0;
      ignore = 1'b0;
      if (int'(req.line) >= msc_pkg::LINES) begin
         err = 1'b1;
      end else if (!snoop) begin
         if (st inside {msc_pkg::ST_IS, msc_pkg::ST_IM, msc_pkg::ST_SM}) begin
            ignore = 1'b1;
         end else if (!(msg inside {msc_pkg::MSG_LOAD, msc_pkg::MSG_STORE})) begin
            err = 1'b1;
         end else begin
            case (st)
               msc_pkg::ST_I: begin
                  miss = 1'b1;
                  if (msg == msc_pkg::MSG_LOAD) begin
                     gets = 1'b1;
                     nst  = msc_pkg::ST_IS;
                  end else begin
                     getm = 1'b1;
                     nst  = msc_pkg::ST_IM;
                  end
               end
               msc_pkg::ST_S, msc_pkg::ST_O: begin
                  if (msg == msc_pkg::MSG_LOAD) begin
                     tocpu = 1'b1;
                  end else begin
                     if (st == msc_pkg::ST_O) begin
                        nown = 1'b1;
                     end
                     getm = 1'b1;
                     miss = 1'b1;
                     nst  = msc_pkg::ST_SM;
                  end
               end
               msc_pkg::ST_M: begin
                  tocpu = 1'b1;
               end
               default: begin
                  err = 1'b1;
               end
            endcase
         end
      end else begin
         if (!(msg inside {msc_pkg::MSG_GETS, msc_pkg::MSG_GETM, msc_pkg::MSG_DATA})) begin
            err = 1'b1;
         end else begin
            case (st)
               msc_pkg::ST_I: begin
                  nst = st;
               end
               msc_pkg::ST_S: begin
                  if (msg == msc_pkg::MSG_GETM) begin
                     nst = msc_pkg::ST_I;
                  end
               end
               msc_pkg::ST_O: begin
                  if (msg != msc_pkg::MSG_DATA) begin
                     shr   = 1'b1;
                     onbus = 1'b1;
                     if (msg == msc_pkg::MSG_GETM) begin
                        nst = msc_pkg::ST_I;
                     end
                  end
               end
               msc_pkg::ST_M: begin
                  if (msg != msc_pkg::MSG_DATA) begin
                     shr   = 1'b1;
                     onbus = 1'b1;
                     nst   = (msg == msc_pkg::MSG_GETS) ? msc_pkg::ST_O : msc_pkg::ST_I;
                  end
               end
               msc_pkg::ST_IS, msc_pkg::ST_IM: begin
                  if (msg == msc_pkg::MSG_DATA) begin
                     tocpu = 1'b1;
                     nst   = (st == msc_pkg::ST_IS) ? msc_pkg::ST_S : msc_pkg::ST_M;
                  end
               end
               msc_pkg::ST_SM: begin
                  if (msg == msc_pkg::MSG_DATA) begin
                     nown  = 1'b0;
                     tocpu = 1'b1;
                     nst   = msc_pkg::ST_M;
                  end else if (cur.owner && !req.shared_in) begin
                     shr   = 1'b1;
                     onbus = 1'b1;
                  end
               end
               default: begin
                  err = 1'b1;
               end
            endcase
         end
      end
   end

   assign emit = gets | getm | tocpu | onbus;

   // Write back only when the request was legal and not ignored.
   assign write_en  = !err && !ignore;
   assign nxt.state = nst;
   assign nxt.owner = nown;

   // Result assembly; an illegal request reports the error alone.
   always_comb begin
      rsp = '0;
      if (err) begin
         rsp.error = 1'b1;
      end else begin
         rsp.issue_gets    = gets;
         rsp.issue_getm    = getm;
         rsp.data_to_cpu   = tocpu;
         rsp.data_on_bus   = onbus;
         rsp.dest_id       = onbus ? req.src_id : '0;
         rsp.assert_shared = shr;
         rsp.addr_out      = emit ? req.addr : '0;
         rsp.miss          = miss;
      end
   end

endmodule

`default_nettype wire

/* rtl/mosi_snoop_coherence_controller.sv */
// Top level of the snooping MOSI coherence controller.
`default_nettype none

// Each transfer on the req_ side is either a processor LOAD/STORE (req_tuser low) or a
// snooped GETS/GETM/DATA (req_tuser high) for one line of a 256-entry state table; the block
// answers with exactly one rsp_ transfer that carries the bus request to issue, the data
// movements, the shared-line drive, the miss flag and an error flag for illegal messages.
// The table lives in one synchronous RAM with a registered read port, and every item does a
// read-modify-write of its entry: the read is issued in the cycle the transfer is accepted,
// the update and the result register are written once the lookup finishes, when the result
// register is free or being emptied. The next item is accepted once that write-back is done,
// so a request always sees the state left by the one before it. Per-entry valid bits make
// the whole table read as invalid right after reset, so no clearing pass is needed and the
// block takes transfers from the first cycle after reset. The result register lets one
// finished result wait for rsp_tready while the next item is already accepted and read.
module mosi_snoop_coherence_controller (
   input  wire logic        clock,
   input  wire logic        reset,
   // req_tdata: msg[2:0], line[10:3], addr[42:11], src_id[46:43], shared_in[47]
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [47:0] req_tdata,
   // req_tuser: req_type (0 processor request, 1 snooped bus message)
   input  wire logic        req_tuser,
   // rsp_tdata: issue_gets[0], issue_getm[1], data_to_cpu[2], data_on_bus[3],
   //            dest_id[7:4], assert_shared[8], addr_out[40:9], miss[41], error[42],
   //            zero fill[47:43]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0]      rsp_tdata
);

   msc_pkg::ctl_state_type ctl_state_ff, ctl_state_in;
   msc_pkg::req_type       req_ff;
   logic                   snoop_ff;
   msc_pkg::rsp_type       rsp_ff, rsp_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [msc_pkg::LINES-1:0] valid_ff;

   msc_pkg::req_type   req_in;
   msc_pkg::entry_type ram_rdata;
   msc_pkg::entry_type cur_entry;
   msc_pkg::entry_type nxt_entry;
   logic               xf_write;
   logic               req_fire;
   logic               finish;
   logic               ram_we;
   logic [msc_pkg::LINE_BITS-1:0] rd_idx;
   logic [msc_pkg::LINE_BITS-1:0] wr_idx;

   assign req_in   = msc_pkg::req_type'(req_tdata[msc_pkg::REQ_W-1:0]);
   assign req_fire = req_tvalid && req_tready;
   assign rd_idx   = req_in.line[msc_pkg::LINE_BITS-1:0];
   assign wr_idx   = req_ff.line[msc_pkg::LINE_BITS-1:0];

   // The lookup finishes once the result register is free or being emptied.
   assign finish = (ctl_state_ff == msc_pkg::CTL_LOOKUP) && (!rsp_valid_ff || rsp_tready);
   assign ram_we = finish && xf_write;

   // Sequencer next state.
   always_comb begin
      ctl_state_in = ctl_state_ff;
      case (ctl_state_ff)
         msc_pkg::CTL_IDLE: begin
            if (req_tvalid) begin
               ctl_state_in = msc_pkg::CTL_LOOKUP;
            end
         end
         msc_pkg::CTL_LOOKUP: begin
            if (finish) begin
               ctl_state_in = msc_pkg::CTL_IDLE;
            end
         end
         default: begin
            ctl_state_in = msc_pkg::CTL_IDLE;
         end
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      case (ctl_state_ff)
         msc_pkg::CTL_IDLE: begin
            req_tready = 1'b1;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_state_ff <= msc_pkg::CTL_IDLE;
      end else begin
         ctl_state_ff <= ctl_state_in;
      end
   end

   // Request capture for the lookup cycle.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         req_ff   <= req_in;
         snoop_ff <= req_tuser;
      end
   end

   // Line state table.
   msc_ram #(
      .WIDTH (msc_pkg::ENTRY_W),
      .DEPTH (msc_pkg::LINES)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (wr_idx),
      .wdata (nxt_entry),
      .re    (req_fire),
      .raddr (rd_idx),
      .rdata (ram_rdata)
   );

   // Entries never written since reset read as invalid with the owner flag clear.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (ram_we) begin
         valid_ff[wr_idx] <= 1'b1;
      end
   end

   always_comb begin
      cur_entry = '0;
      cur_entry.state = msc_pkg::ST_I;
      if (valid_ff[wr_idx]) begin
         cur_entry = ram_rdata;
      end
   end

   // Protocol transition for the captured request.
   msc_xform u_xform (
      .snoop    (snoop_ff),
      .req      (req_ff),
      .cur      (cur_entry),
      .nxt      (nxt_entry),
      .write_en (xf_write),
      .rsp      (rsp_in)
   );

   // Result register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(msc_pkg::RSP_BYTE_W - msc_pkg::RSP_W){1'b0}}, rsp_ff};

   // An accepted request always moves the sequencer into the lookup.
   a_fire_lookup: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> ctl_state_ff == msc_pkg::CTL_LOOKUP)
      else $error("accepted request did not start a lookup");

   // The table is written only at the end of a lookup.
   a_write_in_lookup: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> ctl_state_ff == msc_pkg::CTL_LOOKUP && (!rsp_valid_ff || rsp_tready))
      else $error("table written outside a completing lookup");

   // An error result carries no other indication.
   a_error_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_ff.error |-> !rsp_ff.issue_gets && !rsp_ff.issue_getm &&
         !rsp_ff.data_to_cpu && !rsp_ff.data_on_bus && !rsp_ff.assert_shared &&
         !rsp_ff.miss && rsp_ff.addr_out == '0 && rsp_ff.dest_id == '0)
      else $error("error result carries other indications");

   // At most one bus request is issued per result.
   a_one_request: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> $onehot0({rsp_ff.issue_gets, rsp_ff.issue_getm}))
      else $error("both GETS and GETM issued");

   // A destination id only comes with data driven on the bus.
   a_dest_with_data: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_ff.dest_id != '0 |-> rsp_ff.data_on_bus)
      else $error("destination id without bus data");

endmodule

`default_nettype wire

/* bench/tb.sv */
// Self-checking bench for the snooping MOSI coherence controller with a line-table predictor.
module tb;
   import msc_pkg::*;

   localparam int  CYCLE_LIMIT = 300000;
   localparam bit  PROC        = 1'b0;
   localparam bit  SNOOP       = 1'b1;
   // Message codes that no protocol message uses.
   localparam logic [2:0] MSG_SPARE_LO = 3'd5;
   localparam logic [2:0] MSG_SPARE_HI = 3'd7;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata   = '0;
   logic        req_tuser   = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [47:0] rsp_tdata;

   // Predicted copy of the line table.
   line_state_type line_tab [LINES];
   bit             owner_tab[LINES];
   rsp_type        expected_rsp_q[$];

   bit idle_en     = 1'b1;
   int stall_left  = 0;
   int cycle_count = 0;
   int fail_count  = 0;
   int items_sent  = 0;
   int results_seen = 0;
   int errors_seen = 0;
   int misses_seen = 0;
   int ignored_seen = 0;
   int supplies_seen = 0;

   mosi_snoop_coherence_controller dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // Clock with a 12 unit period.
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Run limit in case the block stops answering.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Run limit of %0d cycles reached with %0d results outstanding.",
                  CYCLE_LIMIT, expected_rsp_q.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Computes the coherence result of one message and updates the predicted table.
   function automatic rsp_type predict_coherence(bit snoop, logic [2:0] msg,
                                                 logic [7:0] line, logic [31:0] addr,
                                                 logic [3:0] src, bit shared);
      rsp_type        r;
      line_state_type cur;
      line_state_type nxt;
      bit             own;
      bit             err;
      r   = '0;
      err = 1'b0;
      if (int'(line) >= LINES) begin
         r.error = 1'b1;
         return r;
      end
      cur = line_tab[line];
      nxt = cur;
      own = owner_tab[line];
      if (!snoop) begin
         // Processor side: requests in a transient state are dropped silently.
         if (cur inside {ST_IS, ST_IM, ST_SM}) begin
            return r;
         end else if (msg != MSG_LOAD && msg != MSG_STORE) begin
            err = 1'b1;
         end else if (cur == ST_I) begin
            r.miss = 1'b1;
            if (msg == MSG_LOAD) begin
               r.issue_gets = 1'b1;
               nxt = ST_IS;
            end else begin
               r.issue_getm = 1'b1;
               nxt = ST_IM;
            end
         end else if (msg == MSG_LOAD || cur == ST_M) begin
            r.data_to_cpu = 1'b1;
         end else if (cur == ST_S || cur == ST_O) begin
            // Upgrade from a shared copy; an owner remembers it must still supply data.
            if (cur == ST_O) own = 1'b1;
            r.issue_getm = 1'b1;
            r.miss       = 1'b1;
            nxt          = ST_SM;
         end else begin
            err = 1'b1;
         end
      end else if (!(msg inside {MSG_GETS, MSG_GETM, MSG_DATA})) begin
         err = 1'b1;
      end else begin
         // Snooped bus traffic.
         case (cur)
            ST_I: ;
            ST_S: if (msg == MSG_GETM) nxt = ST_I;
            ST_O, ST_M: begin
               if (msg != MSG_DATA) begin
                  r.assert_shared = 1'b1;
                  r.data_on_bus   = 1'b1;
                  nxt = (msg == MSG_GETM) ? ST_I : ST_O;
               end
            end
            ST_IS: begin
               if (msg == MSG_DATA) begin
                  r.data_to_cpu = 1'b1;
                  nxt = ST_S;
               end
            end
            ST_IM: begin
               if (msg == MSG_DATA) begin
                  r.data_to_cpu = 1'b1;
                  nxt = ST_M;
               end
            end
            ST_SM: begin
               if (msg == MSG_DATA) begin
                  own = 1'b0;
                  r.data_to_cpu = 1'b1;
                  nxt = ST_M;
               end else if (own && !shared) begin
                  r.assert_shared = 1'b1;
                  r.data_on_bus   = 1'b1;
               end
            end
            default: err = 1'b1;
         endcase
      end
      if (err) begin
         r       = '0;
         r.error = 1'b1;
         return r;
      end
      line_tab[line]  = nxt;
      owner_tab[line] = own;
      if (r.data_on_bus) r.dest_id = src;
      if (r.issue_gets || r.issue_getm || r.data_to_cpu || r.data_on_bus) r.addr_out = addr;
      return r;
   endfunction

   // Prints one mismatch line and counts it.
   task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
      fail_count++;
      if (fail_count <= 40)
         $display("MISMATCH at cycle %0d: %s got 0x%0h, want 0x%0h",
                  cycle_count, what, got, want);
   endtask

   task automatic check_field(string what, longint unsigned got, longint unsigned want);
      if (got !== want) report_mismatch(what, got, want);
   endtask

   // Drives one message, waits for its transfer and records the predicted result.
   task automatic send_item(bit snoop, logic [2:0] msg, logic [7:0] line,
                            logic [31:0] addr, logic [3:0] src, bit shared);
      rsp_type r;
      if (idle_en && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= snoop;
      req_tdata  <= {shared, src, addr, line, msg};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (!snoop && line_tab[line] inside {ST_IS, ST_IM, ST_SM}) ignored_seen++;
      r = predict_coherence(snoop, msg, line, addr, src, shared);
      expected_rsp_q.push_back(r);
      items_sent++;
      if (r.error) errors_seen++;
      if (r.miss) misses_seen++;
      if (r.data_on_bus) supplies_seen++;
   endtask

   // Result side stalls in random bursts while idling is enabled.
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 4) == 0) begin
         stall_left <= $urandom_range(0, 6);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Compares each result transfer with the oldest prediction.
   always @(posedge clock) begin : check_results
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (expected_rsp_q.size() == 0) begin
            report_mismatch("result with nothing outstanding", rsp_tdata, 0);
         end else begin
            want = expected_rsp_q.pop_front();
            got  = rsp_type'(rsp_tdata[RSP_W-1:0]);
            check_field("issue_gets", got.issue_gets, want.issue_gets);
            check_field("issue_getm", got.issue_getm, want.issue_getm);
            check_field("data_to_cpu", got.data_to_cpu, want.data_to_cpu);
            check_field("data_on_bus", got.data_on_bus, want.data_on_bus);
            check_field("dest_id", got.dest_id, want.dest_id);
            check_field("assert_shared", got.assert_shared, want.assert_shared);
            check_field("addr_out", got.addr_out, want.addr_out);
            check_field("miss", got.miss, want.miss);
            check_field("error", got.error, want.error);
            check_field("zero fill", rsp_tdata[47:RSP_W], 0);
         end
      end
   end

   // Walks line 0 through the I, IS, S, SM, M and O states, owner handoff included.
   task automatic test_line_lifecycle();
      send_item(PROC,  MSG_LOAD,  8'd0, 32'h0000_0000, 4'd0, 1'b0);
      send_item(PROC,  MSG_STORE, 8'd0, 32'h1234_5678, 4'd1, 1'b0);
      send_item(SNOOP, MSG_DATA,  8'd0, 32'h1234_5678, 4'd2, 1'b0);
      send_item(PROC,  MSG_LOAD,  8'd0, 32'h0000_0040, 4'd3, 1'b0);
      send_item(PROC,  MSG_STORE, 8'd0, 32'h0000_0040, 4'd4, 1'b1);
      send_item(SNOOP, MSG_GETS,  8'd0, 32'h0000_0080, 4'd5, 1'b0);
      send_item(SNOOP, MSG_DATA,  8'd0, 32'h0000_0080, 4'd6, 1'b0);
      send_item(PROC,  MSG_STORE, 8'd0, 32'hA5A5_A5A5, 4'd7, 1'b0);
      send_item(SNOOP, MSG_GETS,  8'd0, 32'h5A5A_5A5A, 4'd5, 1'b0);
      send_item(PROC,  MSG_LOAD,  8'd0, 32'h0F0F_0F0F, 4'd8, 1'b0);
      send_item(PROC,  MSG_STORE, 8'd0, 32'hF0F0_F0F0, 4'd9, 1'b0);
      send_item(SNOOP, MSG_GETM,  8'd0, 32'h8000_0001, 4'd10, 1'b0);
      send_item(SNOOP, MSG_GETS,  8'd0, 32'h8000_0002, 4'd11, 1'b1);
      send_item(PROC,  MSG_LOAD,  8'd0, 32'h8000_0003, 4'd12, 1'b0);
      send_item(SNOOP, MSG_DATA,  8'd0, 32'h8000_0004, 4'd13, 1'b0);
      send_item(SNOOP, MSG_GETM,  8'd0, 32'h8000_0005, 4'd14, 1'b1);
   endtask

   // Illegal messages, unused codes and the extreme line, address and id values.
   task automatic test_illegal_and_extremes();
      send_item(PROC,  MSG_STORE,    8'd255, 32'hFFFF_FFFF, 4'd15, 1'b1);
      send_item(SNOOP, MSG_DATA,     8'd255, 32'hFFFF_FFFF, 4'd15, 1'b1);
      send_item(SNOOP, MSG_LOAD,     8'd255, 32'hFFFF_FFFF, 4'd15, 1'b0);
      send_item(PROC,  MSG_GETS,     8'd255, 32'hFFFF_FFFF, 4'd15, 1'b0);
      send_item(PROC,  MSG_SPARE_HI, 8'd255, 32'hFFFF_FFFF, 4'd0, 1'b0);
      send_item(SNOOP, MSG_SPARE_LO, 8'd255, 32'hFFFF_FFFF, 4'd0, 1'b1);
      send_item(SNOOP, MSG_GETM,     8'd255, 32'hFFFF_FFFF, 4'd15, 1'b1);
      send_item(PROC,  MSG_LOAD,     8'd170, 32'hAAAA_AAAA, 4'd10, 1'b0);
      send_item(SNOOP, MSG_DATA,     8'd170, 32'h5555_5555, 4'd5, 1'b1);
      send_item(SNOOP, MSG_GETM,     8'd170, 32'h5555_5555, 4'd5, 1'b0);
   endtask

   // Mostly protocol-shaped traffic on a few hot lines, with some noise mixed in.
   task automatic test_random_traffic(int n, bit allow_idle);
      int         counted;
      int         pick;
      logic [7:0] ln;
      logic [2:0] m;
      bit         snoop;
      counted = 0;
      while (counted < n) begin
         if (allow_idle && $urandom_range(0, 39) == 0) idle_en = ~idle_en;
         ln   = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                            : 8'($urandom_range(0, 7));
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            snoop = 1'($urandom_range(0, 1));
            m     = 3'($urandom_range(0, 7));
         end else if (line_tab[ln] inside {ST_IS, ST_IM, ST_SM} && pick < 45) begin
            snoop = SNOOP;
            m     = MSG_DATA;
         end else if (pick < 60) begin
            snoop = PROC;
            m     = $urandom_range(0, 1) ? MSG_STORE : MSG_LOAD;
         end else begin
            snoop = SNOOP;
            case ($urandom_range(0, 2))
               0:       m = MSG_GETS;
               1:       m = MSG_GETM;
               default: m = MSG_DATA;
            endcase
         end
         counted++;
         send_item(snoop, m, ln, $urandom, 4'($urandom_range(0, 15)),
                   1'($urandom_range(0, 1)));
      end
   endtask

   // Closing stretch at full rate on both sides.
   task automatic test_full_rate(int n);
      idle_en = 1'b0;
      test_random_traffic(n, 1'b0);
   endtask

   initial begin
      foreach (line_tab[i]) begin
         line_tab[i]  = ST_I;
         owner_tab[i] = 1'b0;
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_line_lifecycle();
      test_illegal_and_extremes();
      test_random_traffic(1000, 1'b1);
      test_full_rate(150);

      req_tvalid <= 1'b0;
      idle_en = 1'b0;
      while (expected_rsp_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);

      $display("Sent %0d transfers and checked %0d results on the line table.",
               items_sent, results_seen);
      $display("Seen: %0d illegal, %0d misses, %0d bus supplies, %0d dropped in transients.",
               errors_seen, misses_seen, supplies_seen, ignored_seen);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("%0d mismatches found.", fail_count);
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
